@@ sv/lfr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfr_pkg
// shared types and constants of the link fragment reassembler
// ----------------------------------------------------------------------------
package lfr_pkg;

  localparam int BUF_DEPTH = 256;
  localparam int BUF_AW    = $clog2(BUF_DEPTH);
  localparam int LEN_W     = 9;

  typedef enum logic [1:0] {
    OP_RECV  = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_PARTIAL  = 2'd0,
    ST_COMPLETE = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_READ     = 2'd3
  } status_t;

  localparam logic CFG_BEGIN_MASK = 1'b0;
  localparam logic CFG_END_MASK   = 1'b1;

endpackage
`default_nettype wire

@@ sv/lfr_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lfr_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module lfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ sv/link_fragment_reassembler_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// link_fragment_reassembler_unit
// rebuilds messages from begin/end flagged link packets, one byte per item
// ----------------------------------------------------------------------------
// One transaction per clock is accepted and one result per clock can leave
// while out_ready does not stall the output. Each item updates the fill count
// and the packet flags in the cycle it is accepted and writes at most one byte
// into a 256 x 8 message ram; the result passes through stage 1 (with the
// registered ram read) and then the output register to the out_ port. Bytes of
// opcode 0 that do not end a packet, clears and opcode 3 give no result. The ram
// is not cleared after reset: reading a never-written position returns arbitrary
// data. The flag masks may only be written while the block is idle.
module link_fragment_reassembler_unit
  import lfr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  // configuration
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [7:0]       cfg_wdata,
  // input transactions
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [1:0]       in_opcode,
  input  wire logic [7:0]       in_data_byte,
  input  wire logic             in_is_header,
  input  wire logic             in_is_last,
  input  wire logic [7:0]       in_read_index,
  // result transactions
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [1:0]       out_status,
  output logic      [LEN_W-1:0] out_message_length,
  output logic      [7:0]       out_read_byte
);

  // configuration registers
  logic [7:0] begin_mask_r;
  logic [7:0] end_mask_r;

  // reassembly state
  logic [LEN_W-1:0] fill_r, fill_nxt;
  logic             ends_r, ends_nxt;
  logic             drop_r, drop_nxt;

  // stage 1: result waiting for ram read data
  logic             s1_valid_r, s1_valid_nxt;
  status_t          s1_status_r, s1_status_nxt;
  logic [LEN_W-1:0] s1_len_r, s1_len_nxt;

  // output register
  logic             out_valid_r;
  status_t          out_status_r;
  logic [LEN_W-1:0] out_len_r;
  logic [7:0]       out_byte_r;

  logic             in_fire;
  logic             s1_adv;
  opcode_t          op;

  // ram controls
  logic             ram_we;
  logic             ram_re;
  logic [7:0]       ram_rdata;
  logic             drop_tmp;

  assign op       = opcode_t'(in_opcode);
  // stage 1 moves on whenever the output register is free or being emptied
  assign s1_adv   = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || s1_adv;
  assign in_fire  = in_valid && in_ready;

  // --------------------------------------------------------------------------
  // per-item update: flags, fill count, ram write and result code
  // --------------------------------------------------------------------------
  always_comb begin
    fill_nxt      = fill_r;
    ends_nxt      = ends_r;
    drop_nxt      = drop_r;
    drop_tmp      = drop_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    s1_valid_nxt  = 1'b0;
    s1_status_nxt = ST_PARTIAL;
    s1_len_nxt    = '0;
    if (in_fire) begin
      unique case (op)
        OP_READ: begin
          ram_re        = 1'b1;
          s1_valid_nxt  = 1'b1;
          s1_status_nxt = ST_READ;
          s1_len_nxt    = fill_r;
        end
        OP_CLEAR: begin
          fill_nxt = '0;
        end
        OP_RECV: begin
          if (in_is_header) begin
            // header: begin flag restarts the message, end flag arms completion
            if ((in_data_byte & begin_mask_r) != 8'd0) begin
              fill_nxt = '0;
            end
            ends_nxt = (in_data_byte & end_mask_r) != 8'd0;
            drop_tmp = 1'b0;
          end else if (!drop_r) begin
            if (fill_r[LEN_W-1]) begin
              // buffer full: restart and drop the rest of this packet
              fill_nxt = '0;
              drop_tmp = 1'b1;
            end else begin
              ram_we   = 1'b1;
              fill_nxt = fill_r + LEN_W'(1);
            end
          end
          drop_nxt = drop_tmp;
          if (in_is_last) begin
            s1_valid_nxt = 1'b1;
            drop_nxt     = 1'b0;
            if (drop_tmp) begin
              s1_status_nxt = ST_OVERFLOW;
            end else if (ends_nxt) begin
              s1_status_nxt = ST_COMPLETE;
              s1_len_nxt    = fill_nxt;
            end else begin
              s1_status_nxt = ST_PARTIAL;
            end
          end
        end
        default: begin
          // unused opcode, ignored
        end
      endcase
    end
  end

  lfr_ram #(
    .WIDTH (8),
    .DEPTH (BUF_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (fill_r[BUF_AW-1:0]),
    .wdata (in_data_byte),
    .re    (ram_re),
    .raddr (in_read_index[BUF_AW-1:0]),
    .rdata (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      begin_mask_r <= 8'd1;
      end_mask_r   <= 8'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BEGIN_MASK: begin_mask_r <= cfg_wdata;
        CFG_END_MASK:   end_mask_r   <= cfg_wdata;
        default:        ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      ends_r <= 1'b0;
      drop_r <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      ends_r <= ends_nxt;
      drop_r <= drop_nxt;
    end
  end

  // stage 1 holds while stalled; ram read data holds too since re is tied to accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_status_r <= s1_status_nxt;
      s1_len_r    <= s1_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_status_r <= s1_status_r;
      out_len_r    <= s1_len_r;
      out_byte_r   <= (s1_status_r == ST_READ) ? ram_rdata : 8'd0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_message_length = out_len_r;
  assign out_read_byte      = out_byte_r;

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_fill_bound : assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= LEN_W'(BUF_DEPTH))
    else $error("fill count above buffer depth");

  a_len_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r == ST_PARTIAL || out_status_r == ST_OVERFLOW)
      |-> out_len_r == '0)
    else $error("nonzero length on partial or overflow result");

  a_byte_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != ST_READ |-> out_byte_r == 8'd0)
    else $error("read byte set on a non-read result");

  a_no_drop_after_last : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && op == OP_RECV && in_is_last |=> !drop_r)
    else $error("dropping state survived the end of a packet");

endmodule
`default_nettype wire

@@ sim/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for link_fragment_reassembler_unit: directed packets,
// then random well-formed messages mixed with reads, clears and noise, under
// several flag mask settings; every result is checked against a predictor
// ----------------------------------------------------------------------------
module tb;
  import lfr_pkg::*;

  localparam int NUM_PHASES      = 7;
  localparam int ITEMS_PER_PHASE = 290;
  localparam int DRAIN_CYCLES    = 6;
  localparam int CYCLE_LIMIT     = 600000;

  typedef struct packed {
    opcode_t    op;
    logic [7:0] data;
    logic       hdr;
    logic       last;
    logic [7:0] idx;
  } link_item_t;

  typedef struct packed {
    status_t          st;
    logic [LEN_W-1:0] len;
    logic [7:0]       rbyte;
  } link_result_t;

  // clock, reset and block ports; every input known from time zero
  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_we = 1'b0;
  logic             cfg_index = CFG_BEGIN_MASK;
  logic [7:0]       cfg_wdata = 8'h00;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [1:0]       in_opcode = OP_NONE;
  logic [7:0]       in_data_byte = 8'h00;
  logic             in_is_header = 1'b0;
  logic             in_is_last = 1'b0;
  logic [7:0]       in_read_index = 8'h00;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [1:0]       out_status;
  logic [LEN_W-1:0] out_message_length;
  logic [7:0]       out_read_byte;

  // predictor state: mirror of the message ram, counters, flags and masks
  logic [7:0]       msg_mem [0:BUF_DEPTH-1];
  logic [LEN_W-1:0] fill_cnt = '0;
  logic             ends_msg = 1'b0;
  logic             dropping = 1'b0;
  logic [7:0]       begin_mask = 8'h01;
  logic [7:0]       end_mask = 8'h02;
  int               mem_hw = 0;   // ram positions 0..mem_hw-1 hold written data

  link_item_t   pending_items [$];
  link_result_t expected_results [$];
  link_item_t   cur_item;
  link_result_t cur_result;
  link_result_t oldest;
  int           errors = 0;
  int           loaded = 0;
  int           cycles = 0;

  // sender burst/gap bookkeeping, receiver stall pattern
  int burst_left = 0;
  int gap_left = 0;
  int seg_left = 0;
  int seg_mode = 0;

  link_fragment_reassembler_unit DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_opcode          (in_opcode),
    .in_data_byte       (in_data_byte),
    .in_is_header       (in_is_header),
    .in_is_last         (in_is_last),
    .in_read_index      (in_read_index),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_message_length (out_message_length),
    .out_read_byte      (out_read_byte)
  );

  always #10 clk = ~clk;

  // predicts the result of one accepted transaction and updates the mirror
  function automatic bit reassemble(input link_item_t it, output link_result_t res);
    res = '{ST_PARTIAL, '0, '0};
    case (it.op)
      OP_READ: begin
        res.st    = ST_READ;
        res.len   = fill_cnt;
        res.rbyte = msg_mem[it.idx];
        return 1'b1;
      end
      OP_CLEAR: begin
        // clear keeps the header flags and the dropping state
        fill_cnt = '0;
        return 1'b0;
      end
      OP_RECV: begin
        if (it.hdr) begin
          if ((it.data & begin_mask) != 8'h00) fill_cnt = '0;
          ends_msg = (it.data & end_mask) != 8'h00;
          dropping = 1'b0;
        end else if (!dropping) begin
          if (fill_cnt >= BUF_DEPTH) begin
            // buffer full: restart the count and drop the rest of the packet
            fill_cnt = '0;
            dropping = 1'b1;
          end else begin
            msg_mem[fill_cnt[BUF_AW-1:0]] = it.data;
            fill_cnt = fill_cnt + 1'b1;
            if (fill_cnt > mem_hw) mem_hw = fill_cnt;
          end
        end
        if (!it.last) return 1'b0;
        if (dropping) begin
          res.st = ST_OVERFLOW;
        end else if (ends_msg) begin
          res.st  = ST_COMPLETE;
          res.len = fill_cnt;
        end
        dropping = 1'b0;
        return 1'b1;
      end
      default: return 1'b0;  // unused opcode is ignored
    endcase
  endfunction

  // driver: bursts of transactions with random gaps; predicts on acceptance
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        if (reassemble(cur_item, cur_result)) expected_results.push_back(cur_result);
      end
      if (in_valid && !in_ready) begin
        // hold the payload until the transaction is taken
        in_valid <= 1'b1;
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        cur_item = pending_items.pop_front();
        // a read only ever targets a position that has been written
        if (cur_item.op == OP_READ) begin
          if (mem_hw == 0) cur_item.op = OP_CLEAR;
          else if (cur_item.idx >= mem_hw) cur_item.idx = cur_item.idx % mem_hw;
        end
        in_opcode     <= cur_item.op;
        in_data_byte  <= cur_item.data;
        in_is_header  <= cur_item.hdr;
        in_is_last    <= cur_item.last;
        in_read_index <= cur_item.idx;
        in_valid      <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left   = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: stretches of always-ready, random stalls and fixed stall patterns
  always @(posedge clk) begin
    if (seg_left == 0) begin
      seg_mode = $urandom_range(0, 3);
      seg_left = $urandom_range(10, 150);
    end
    seg_left--;
    case (seg_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 3) != 0);
      2:       out_ready <= (seg_left % 5) < 2;
      default: out_ready <= (seg_left % 16) >= 12;
    endcase
  end

  // monitor: each result against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result: status %0d length %0d byte %0d",
               out_status, out_message_length, out_read_byte);
        errors++;
      end else begin
        oldest = expected_results.pop_front();
        if (out_status !== oldest.st) begin
          $error("status: expected %0d, actual %0d", oldest.st, out_status);
          errors++;
        end
        if (out_message_length !== oldest.len) begin
          $error("message_length: expected %0d, actual %0d", oldest.len,
                 out_message_length);
          errors++;
        end
        if (out_read_byte !== oldest.rbyte) begin
          $error("read_byte: expected %0d, actual %0d", oldest.rbyte, out_read_byte);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  task automatic push(opcode_t op, logic [7:0] d, logic h, logic l, logic [7:0] ix);
    pending_items.push_back('{op, d, h, l, ix});
    if (op != OP_NONE) loaded++;
  endtask

  // header byte whose begin/end flags match the request under the current masks, if 64 random tries find one
  function automatic logic [7:0] make_header(bit want_begin, bit want_end);
    logic [7:0] b;
    int         tries;
    b = $urandom_range(0, 255);
    for (tries = 0; tries < 64; tries++) begin
      if ((((b & begin_mask) != 8'h00) == want_begin) &&
          (((b & end_mask) != 8'h00) == want_end)) break;
      b = $urandom_range(0, 255);
    end
    return b;
  endfunction

  // one link packet: header then n payload bytes, last flag on the final byte
  task automatic send_packet(logic [7:0] hdr_byte, int n);
    int i;
    push(OP_RECV, hdr_byte, 1'b1, n == 0, $urandom_range(0, 255));
    for (i = 0; i < n; i++)
      push(OP_RECV, $urandom_range(0, 255), 1'b0, i == n - 1, $urandom_range(0, 255));
  endtask

  task automatic payload_length(output int n);
    int r;
    r = $urandom_range(0, 99);
    if (r < 90)      n = $urandom_range(0, 6);
    else if (r < 99) n = $urandom_range(7, 40);
    else             n = $urandom_range(250, 270);  // may be long enough to overflow
  endtask

  task automatic load_directed();
    push(OP_RECV,  8'h01, 1'b1, 1'b0, 8'h00);  // begin header
    push(OP_RECV,  8'h00, 1'b0, 1'b0, 8'hFF);
    push(OP_RECV,  8'hFF, 1'b0, 1'b0, 8'h00);
    push(OP_RECV,  8'hA5, 1'b0, 1'b1, 8'h00);  // ends packet, not message: partial
    push(OP_RECV,  8'h02, 1'b1, 1'b0, 8'h00);  // end header, count kept
    push(OP_RECV,  8'h5A, 1'b0, 1'b1, 8'h00);  // complete, length 4
    push(OP_READ,  8'h00, 1'b0, 1'b0, 8'h00);
    push(OP_READ,  8'hFF, 1'b1, 1'b1, 8'h03);
    push(OP_RECV,  8'h03, 1'b1, 1'b1, 8'h00);  // header that is also last
    push(OP_RECV,  8'h00, 1'b1, 1'b1, 8'hFF);  // flagless header, last
    push(OP_RECV,  8'h11, 1'b0, 1'b1, 8'h00);  // payload with no header
    push(OP_RECV,  8'hFE, 1'b1, 1'b0, 8'h00);  // end flag, no begin
    push(OP_RECV,  8'h22, 1'b0, 1'b0, 8'h00);
    push(OP_RECV,  8'h33, 1'b0, 1'b1, 8'h00);  // complete, length 3
    push(OP_CLEAR, 8'hFF, 1'b1, 1'b1, 8'hFF);
    push(OP_READ,  8'h00, 1'b0, 1'b0, 8'h02);  // data survives a clear
    push(OP_NONE,  8'hFF, 1'b1, 1'b1, 8'hFF);  // unused opcode
    push(OP_NONE,  8'h00, 1'b0, 1'b0, 8'h00);
    push(OP_RECV,  8'hFF, 1'b1, 1'b1, 8'h00);  // all flags, no payload
    push(OP_RECV,  8'h44, 1'b0, 1'b1, 8'h00);  // headerless, last flags still apply
  endtask

  task automatic load_random(int target, bit start_long);
    int r;
    int k;
    int p;
    int n;
    int i;
    bit fb;
    bit fe;
    loaded = 0;
    // fill the whole ram once and run into an overflow
    if (start_long) send_packet(make_header(1'b1, 1'b1), 260);
    while (loaded < target) begin
      r = $urandom_range(0, 99);
      if (r < 55) begin
        // well-formed message of one to three packets
        k = $urandom_range(1, 3);
        for (p = 0; p < k; p++) begin
          fb = (p == 0);
          fe = (p == k - 1);
          if ($urandom_range(0, 9) == 0) begin
            fb = $urandom_range(0, 1);
            fe = $urandom_range(0, 1);
          end
          payload_length(n);
          send_packet(make_header(fb, fe), n);
        end
      end else if (r < 65) begin
        push(OP_READ, $urandom_range(0, 255), $urandom_range(0, 1), $urandom_range(0, 1),
             $urandom_range(0, 255));
      end else if (r < 70) begin
        push(OP_CLEAR, $urandom_range(0, 255), $urandom_range(0, 1), $urandom_range(0, 1),
             $urandom_range(0, 255));
      end else if (r < 75) begin
        push(OP_NONE, $urandom_range(0, 255), $urandom_range(0, 1), $urandom_range(0, 1),
             $urandom_range(0, 255));
      end else if (r < 85) begin
        // broken packet: payload with no header, last flag random
        n = $urandom_range(1, 4);
        for (i = 0; i < n; i++)
          push(OP_RECV, $urandom_range(0, 255), 1'b0, $urandom_range(0, 1),
               $urandom_range(0, 255));
      end else begin
        push(opcode_t'($urandom_range(0, 3)), $urandom_range(0, 255), $urandom_range(0, 1),
             $urandom_range(0, 1), $urandom_range(0, 255));
      end
    end
  endtask

  // waits until nothing is queued, in flight or expected, then lets the
  // pipeline drain items that cause no result
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_masks(logic [7:0] b, logic [7:0] e);
    @(posedge clk);
    cfg_we     <= 1'b1;
    cfg_index  <= CFG_BEGIN_MASK;
    cfg_wdata  <= b;
    begin_mask = b;
    @(posedge clk);
    cfg_index  <= CFG_END_MASK;
    cfg_wdata  <= e;
    end_mask   = e;
    @(posedge clk);
    cfg_we     <= 1'b0;
  endtask

  initial begin : stimulus
    logic [7:0] bm [NUM_PHASES];
    logic [7:0] em [NUM_PHASES];
    int ph;
    // mask settings per phase: reset values, extremes, single bits, random
    bm = '{8'h01, 8'hFF, 8'h00, 8'h80, 8'h00, 8'h00, 8'hFF};
    em = '{8'h02, 8'hFF, 8'h00, 8'h01, 8'h00, 8'hFF, 8'h00};
    bm[4] = $urandom_range(0, 255);
    em[4] = $urandom_range(0, 255);
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      wait_idle();
      write_masks(bm[ph], em[ph]);
      @(negedge clk);
      if (ph == 0) load_directed();
      load_random(ITEMS_PER_PHASE, ph == 0);
    end
    wait_idle();
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
